// ===== rtl/mmn_pkg.sv =====
// Shared types and constants of the min/max normalizer.
package mmn_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DEPTH_DEF = 64;

  typedef enum logic [0:0] {
    CFG_OUT_MIN = 1'b0,
    CFG_OUT_MAX = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_CALC,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_PUSH
  } mmn_state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     final_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] scaled;
    logic                     flat;
    logic                     last_out;
  } out_word_t;

  // Divider result: full means the quotient is 1.0 or more.
  typedef struct packed {
    logic              done;
    logic              full;
    logic [DATA_W-1:0] frac;
  } div_res_t;

endpackage

// ===== rtl/mmn_sample_ram.sv =====
// Sample store: one write port, one registered read port.
module mmn_sample_ram #(
  parameter int unsigned DEPTH = mmn_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [$clog2(DEPTH)-1:0]          waddr_i,
  input  logic [mmn_pkg::DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0]          raddr_i,
  output logic [mmn_pkg::DATA_W-1:0]        rdata_o
);
  import mmn_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/mmn_divider.sv =====
// Restoring divider: num / den as a fraction with 32 bits, one bit per cycle.
module mmn_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mmn_pkg::DATA_W-1:0] num_i,
  input  logic [mmn_pkg::DATA_W-1:0] den_i,
  output mmn_pkg::div_res_t          res_o
);
  import mmn_pkg::*;

  localparam int unsigned STEP_W = $clog2(DATA_W);

  logic              busy_q, done_q, full_q;
  logic [STEP_W-1:0] step_q;
  logic [DATA_W-1:0] rem_q, rem_d, den_q, quot_q;
  logic [DATA_W:0]   rem_sh, diff;
  logic              qbit;

  assign rem_sh = {rem_q, 1'b0};
  assign diff   = rem_sh - {1'b0, den_q};
  assign qbit   = (rem_sh >= {1'b0, den_q});
  assign rem_d  = qbit ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == STEP_W'(DATA_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(DATA_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      full_q <= (num_i >= den_i);
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[DATA_W-2:0], qbit};
    end
  end

  assign res_o.done = done_q;
  assign res_o.full = full_q;
  assign res_o.frac = quot_q;

endmodule

// ===== rtl/min_max_normalizer.sv =====
// Top level of the min/max normalizer: load sequencer, scaling path, output register.
//
//   port group   dir  handshake              payload
//   in           in   in_valid_i/in_ready_o  in_i (sample, final_sample)
//   out          out  out_valid_o/out_ready_i out_o (scaled, flat, last_out)
//   cfg          in   cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// Loading accepts one sample per cycle. After the final sample, or the DEPTH-th,
// each result passes read, setup, the 32-step shared divider and its done flag,
// multiply, sum and push; a flat set goes from setup straight to push. Input ready
// is low until the last result is in the output register. A stalled output holds
// the sequencer in its push step. Reset clears the control state and sets the
// target range to [0, 1.0]; the sample store needs no clearing.
module min_max_normalizer #(
  parameter int unsigned DEPTH = mmn_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  mmn_pkg::in_word_t          in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output mmn_pkg::out_word_t         out_o,
  input  logic                       cfg_we_i,
  input  mmn_pkg::cfg_reg_e          cfg_idx_i,
  input  logic [mmn_pkg::DATA_W-1:0] cfg_wdata_i
);
  import mmn_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);

  mmn_state_e state_q, state_d;

  logic [IDX_W-1:0]         cnt_q, idx_q, last_idx_q;
  logic signed [DATA_W-1:0] min_q, max_q, out_min_q, out_max_q;
  logic [DATA_W-1:0]        rd_data, mag_q, prod_q;
  logic signed [DATA_W-1:0] res_q;
  logic                     neg_q, out_valid_q;
  out_word_t                out_q;

  logic       in_acc, set_end, flat, out_free, last_res;
  logic       div_start, push;
  div_res_t   div_res;

  logic [DATA_W:0]          dist_w, range_w, span_w;
  logic [2*DATA_W-1:0]      mult_w;
  logic [DATA_W+1:0]        sum_w;
  logic signed [DATA_W-1:0] sat_w;

  assign in_acc   = in_valid_i && in_ready_o;
  assign set_end  = in_i.final_sample || (cnt_q == IDX_W'(DEPTH - 1));
  assign flat     = (min_q == max_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign last_res = (idx_q == last_idx_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: if (in_acc && set_end) state_d = ST_READ;
      ST_READ: state_d = ST_CALC;
      ST_CALC: state_d = flat ? ST_PUSH : ST_DIV;
      ST_DIV:  if (div_res.done) state_d = ST_MUL;
      ST_MUL:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_PUSH;
      ST_PUSH: if (out_free) state_d = last_res ? ST_LOAD : ST_READ;
      default: state_d = ST_LOAD;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    push       = 1'b0;
    unique case (state_q)
      ST_LOAD: in_ready_o = 1'b1;
      ST_CALC: div_start  = !flat;
      ST_PUSH: push       = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      cnt_q      <= '0;
      idx_q      <= '0;
      last_idx_q <= '0;
      min_q      <= '0;
      max_q      <= '0;
      out_min_q  <= '0;
      out_max_q  <= DATA_W'(65536);
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_OUT_MIN: out_min_q <= cfg_wdata_i;
          CFG_OUT_MAX: out_max_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        if (cnt_q == '0) begin
          min_q <= in_i.sample;
          max_q <= in_i.sample;
        end else begin
          if (in_i.sample < min_q) min_q <= in_i.sample;
          if (in_i.sample > max_q) max_q <= in_i.sample;
        end
        if (set_end) begin
          last_idx_q <= cnt_q;
          cnt_q      <= '0;
        end else begin
          cnt_q <= cnt_q + IDX_W'(1);
        end
      end
      if (push) begin
        idx_q <= last_res ? '0 : idx_q + IDX_W'(1);
      end
    end
  end

  mmn_sample_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(cnt_q),
    .wdata_i(in_i.sample),
    .raddr_i(idx_q),
    .rdata_o(rd_data)
  );

  assign dist_w  = {rd_data[DATA_W-1], rd_data} - {min_q[DATA_W-1], min_q};
  assign range_w = {max_q[DATA_W-1], max_q} - {min_q[DATA_W-1], min_q};
  assign span_w  = {out_max_q[DATA_W-1], out_max_q} - {out_min_q[DATA_W-1], out_min_q};

  mmn_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (dist_w[DATA_W-1:0]),
    .den_i  (range_w[DATA_W-1:0]),
    .res_o  (div_res)
  );

  assign mult_w = div_res.frac * mag_q;
  assign sum_w  = {{2{out_min_q[DATA_W-1]}}, out_min_q}
                + (neg_q ? -{2'b00, prod_q} : {2'b00, prod_q});

  always_comb begin
    if (sum_w[DATA_W+1:DATA_W-1] == 3'b000 || sum_w[DATA_W+1:DATA_W-1] == 3'b111) begin
      sat_w = sum_w[DATA_W-1:0];
    end else if (sum_w[DATA_W+1]) begin
      sat_w = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_w = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // scaling path registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) begin
      neg_q <= span_w[DATA_W];
      mag_q <= span_w[DATA_W] ? DATA_W'(-span_w) : span_w[DATA_W-1:0];
      res_q <= out_min_q;
    end
    if (state_q == ST_MUL) begin
      prod_q <= div_res.full ? mag_q : mult_w[2*DATA_W-1:DATA_W];
    end
    if (state_q == ST_SUM) begin
      res_q <= sat_w;
    end
    if (push) begin
      out_q.scaled   <= res_q;
      out_q.flat     <= flat;
      out_q.last_out <= last_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef NO_ASSERTIONS
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == ST_DIV)
    else $error("divider finished outside its wait step");

  a_idx_zero_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |-> idx_q == '0)
    else $error("result index not cleared while loading");

  a_last_push_reloads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && last_res) |=> (state_q == ST_LOAD && cnt_q == '0 && out_o.last_out))
    else $error("set did not close after its last word");

  a_no_push_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!out_valid_q || out_ready_i))
    else $error("word pushed over a held result");
`endif

endmodule

// ===== tb/sv/mmn_checker.sv =====
// Channel monitor for the min/max normalizer: predicts each scaled word and compares it.
`timescale 1ns / 100ps
module mmn_checker #(
  parameter int unsigned DEPTH = mmn_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  mmn_pkg::in_word_t          in_word_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  mmn_pkg::out_word_t         out_word_i,
  input  logic                       cfg_we_i,
  input  mmn_pkg::cfg_reg_e          cfg_idx_i,
  input  logic [mmn_pkg::DATA_W-1:0] cfg_wdata_i,
  output int                         pending_o,
  output int                         mismatches_o,
  output int                         compared_o
);
  import mmn_pkg::*;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  logic [31:0]        sample_mem [DEPTH];
  logic signed [31:0] low_seen;
  logic signed [31:0] high_seen;
  logic signed [31:0] tgt_lo;
  logic signed [31:0] tgt_hi;
  int unsigned        held;
  mmn_pkg::out_word_t scaled_due [$];
  int                 mism;
  int                 compared;

  // Map s from [lo,hi] onto [omin,omax]; the fraction has 32 fractional bits, truncated.
  function automatic logic signed [31:0] map_to_target(input logic signed [31:0] s, lo, hi,
                                                       input logic signed [31:0] omin, omax);
    longint      range_w;
    longint      dist_w;
    longint      span;
    longint      mag;
    longint      res;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] prod;
    range_w = longint'(hi) - longint'(lo);
    dist_w  = longint'(s) - longint'(lo);
    span    = longint'(omax) - longint'(omin);
    mag     = (span < 0) ? -span : span;
    if (dist_w >= range_w) begin
      quo = 64'd1 << 32;
    end else begin
      rem = dist_w;
      quo = '0;
      for (int i = 0; i < 32; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= range_w) begin
          rem    = rem - range_w;
          quo[0] = 1'b1;
        end
      end
    end
    prod = (quo * mag) >> 32;
    res  = longint'(omin) + ((span < 0) ? -longint'(prod) : longint'(prod));
    if (res > SAT_HI) res = SAT_HI;
    if (res < SAT_LO) res = SAT_LO;
    return res[31:0];
  endfunction

  function automatic void absorb_sample(input mmn_pkg::in_word_t w);
    mmn_pkg::out_word_t o;
    logic               flat;
    if (held == 0) begin
      low_seen  = w.sample;
      high_seen = w.sample;
    end else begin
      if ($signed(w.sample) < low_seen) low_seen = w.sample;
      if ($signed(w.sample) > high_seen) high_seen = w.sample;
    end
    sample_mem[held] = w.sample;
    held++;
    // A full store closes the set even without the final flag.
    if (w.final_sample || held == DEPTH) begin
      flat = (high_seen == low_seen);
      for (int unsigned k = 0; k < held; k++) begin
        o.scaled   = flat ? tgt_lo
                          : map_to_target($signed(sample_mem[k]), low_seen, high_seen,
                                          tgt_lo, tgt_hi);
        o.flat     = flat;
        o.last_out = (k == held - 1);
        scaled_due = {scaled_due, o};
      end
      held = 0;
    end
  endfunction

  function automatic void check_word(input mmn_pkg::out_word_t got);
    mmn_pkg::out_word_t want;
    if (scaled_due.size() == 0) begin
      mism++;
      if (mism <= 10)
        $display("[%0t] word with nothing expected: scaled %h flat %b last %b",
                 $realtime, got.scaled, got.flat, got.last_out);
      return;
    end
    want = scaled_due.pop_front();
    compared++;
    if (got.scaled !== want.scaled || got.flat !== want.flat
        || got.last_out !== want.last_out) begin
      mism++;
      if (mism <= 10)
        $display("[%0t] mismatch: scaled exp %h got %h, flat exp %b got %b, last exp %b got %b",
                 $realtime, want.scaled, got.scaled, want.flat, got.flat,
                 want.last_out, got.last_out);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held      = 0;
      low_seen  = '0;
      high_seen = '0;
      tgt_lo    = 32'sd0;
      tgt_hi    = 32'sd65536;
      scaled_due.delete();
      mism      = 0;
      compared  = 0;
      pending_o    <= 0;
      mismatches_o <= 0;
      compared_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mmn_pkg::CFG_OUT_MIN: tgt_lo = cfg_wdata_i;
          mmn_pkg::CFG_OUT_MAX: tgt_hi = cfg_wdata_i;
          default: ;
        endcase
      end
      // Retire the output word before taking a new sample: its results come later.
      if (out_valid_i && out_ready_i) check_word(out_word_i);
      if (in_valid_i && in_ready_i) absorb_sample(in_word_i);
      pending_o    <= scaled_due.size();
      mismatches_o <= mism;
      compared_o   <= compared;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the normalizer testbench: clock, reset, sample sets, target ranges and verdict.
`timescale 1ns / 100ps
module testbench;
  import mmn_pkg::*;

  localparam int unsigned      DEPTH       = 64;
  localparam int               QUIET_LIMIT = 4000;
  localparam int               ITEM_GOAL   = 180;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  typedef enum int {SPREAD_WIDE, SPREAD_NARROW, SPREAD_EDGES, SPREAD_FLAT} spread_e;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  mmn_pkg::in_word_t          in_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  mmn_pkg::out_word_t         out_o;
  logic                       cfg_we_i;
  mmn_pkg::cfg_reg_e          cfg_idx_i;
  logic [mmn_pkg::DATA_W-1:0] cfg_wdata_i;

  int pending;
  int mismatches;
  int compared;

  logic signed [31:0] set_buf [$];
  bit                 tx_gaps;
  bit                 rx_stalls;
  int                 burst_left;
  int                 rx_left;
  int                 quiet_cycles;
  int                 sample_count;
  int                 set_count;
  int                 full_sets;
  int                 range_updates;

  min_max_normalizer #(.DEPTH(DEPTH)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  mmn_checker #(.DEPTH(DEPTH)) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_word_i    (in_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_i   (out_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pending_o    (pending),
    .mismatches_o (mismatches),
    .compared_o   (compared)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: alternate ready and stall stretches of random length.
  always @(posedge clk_i) begin
    if (!rx_stalls) begin
      out_ready_i <= 1'b1;
    end else if (rx_left > 0) begin
      rx_left--;
    end else begin
      out_ready_i <= !out_ready_i;
      rx_left = out_ready_i ? $urandom_range(1, 12) : $urandom_range(0, 8);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic signed [31:0] s, input logic fin);
    mmn_pkg::in_word_t w;
    int                gap;
    if (tx_gaps && burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    w.sample       = s;
    w.final_sample = fin;
    in_valid_i <= 1'b1;
    in_i       <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sample_count++;
  endtask

  task automatic send_set(input logic fin_last);
    for (int i = 0; i < set_buf.size(); i++)
      send_sample(set_buf[i], (i == set_buf.size() - 1) ? fin_last : 1'b0);
    set_count++;
  endtask

  // Hold the sender until every predicted word has come out.
  task automatic wait_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic set_target(input logic signed [31:0] lo, hi, input bit write_lo, write_hi);
    wait_results();
    repeat (40) @(posedge clk_i);
    if (write_lo) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= mmn_pkg::CFG_OUT_MIN;
      cfg_wdata_i <= lo;
      @(posedge clk_i);
    end
    if (write_hi) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= mmn_pkg::CFG_OUT_MAX;
      cfg_wdata_i <= hi;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    range_updates++;
  endtask

  task automatic random_target();
    bit pick;
    pick = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 4))
      0: set_target(Q_MIN, Q_MAX, 1'b1, 1'b1);
      1: set_target(Q_MAX, Q_MIN, 1'b1, 1'b1);
      2: set_target($urandom, $urandom, 1'b1, 1'b1);
      3: set_target(Q_ONE * ($urandom_range(0, 16) - 8), Q_ONE * ($urandom_range(0, 16) - 8),
                    1'b1, 1'b1);
      default: set_target($urandom, $urandom, pick, !pick);
    endcase
  endtask

  function automatic logic signed [31:0] draw_sample(input spread_e spread,
                                                     input logic signed [31:0] base);
    case (spread)
      SPREAD_WIDE:   return $urandom;
      SPREAD_NARROW: return base + $urandom_range(0, 4095);
      SPREAD_EDGES: begin
        case ($urandom_range(0, 4))
          0:       return Q_MIN;
          1:       return Q_MAX;
          2:       return 32'sd0;
          3:       return -32'sd1;
          default: return $urandom;
        endcase
      end
      default:       return base;
    endcase
  endfunction

  task automatic random_set(input bit fill_store);
    spread_e            spread;
    int                 len;
    logic signed [31:0] base;
    logic               fin_last;
    spread = spread_e'($urandom_range(0, 3));
    base   = $urandom;
    if (fill_store || $urandom_range(0, 11) == 0) begin
      len      = DEPTH;
      fin_last = fill_store ? 1'b0 : 1'($urandom_range(0, 1));
      full_sets++;
    end else begin
      len      = $urandom_range(1, 12);
      fin_last = 1'b1;
    end
    set_buf.delete();
    repeat (len) set_buf = {set_buf, draw_sample(spread, base)};
    send_set(fin_last);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_i          = '0;
    out_ready_i   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = mmn_pkg::CFG_OUT_MIN;
    cfg_wdata_i   = '0;
    tx_gaps       = 1'b0;
    rx_stalls     = 1'b0;
    burst_left    = 0;
    rx_left       = 0;
    quiet_cycles  = 0;
    sample_count  = 0;
    set_count     = 0;
    full_sets     = 0;
    range_updates = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset range [0, 1.0]: single sample, extremes, flat set, mixed signs.
    set_buf = {32'sd0};
    send_set(1'b1);
    set_buf = {Q_MIN, Q_MAX};
    send_set(1'b1);
    rx_stalls <= 1'b1;
    tx_gaps = 1'b1;
    set_buf = {Q_MAX, 32'sd0, -32'sd1, Q_MIN};
    send_set(1'b1);
    set_buf = {32'sd7, 32'sd7, 32'sd7};
    send_set(1'b1);
    set_buf = {Q_ONE, -Q_ONE, 32'sd32768};
    send_set(1'b1);

    // Widest target, inverted target, zero-width target.
    set_target(Q_MIN, Q_MAX, 1'b1, 1'b1);
    set_buf = {Q_MIN, Q_MAX, 32'sh1234_5678};
    send_set(1'b1);
    set_target(Q_MAX, Q_MIN, 1'b1, 1'b1);
    set_buf = {-32'sd5, 32'sd100, 32'sd3, 32'sd100};
    send_set(1'b1);
    set_target(3 * Q_ONE, 3 * Q_ONE, 1'b1, 1'b1);
    set_buf = {32'sd1, 32'sd2};
    send_set(1'b1);

    // Random part, opened by a set that only the full store ends.
    set_target(32'sd0, Q_ONE, 1'b1, 1'b1);
    random_set(1'b1);
    while (sample_count < ITEM_GOAL) begin
      if ($urandom_range(0, 3) == 0) random_target();
      tx_gaps = ($urandom_range(0, 2) != 0);
      rx_stalls <= ($urandom_range(0, 2) != 0);
      random_set(1'b0);
    end

    wait_results();
    repeat (60) @(posedge clk_i);
    $display("Covered %0d samples in %0d sets (%0d reaching the store depth), %0d range updates.",
             sample_count, set_count, full_sets, range_updates);
    $display("%0d scaled words compared, %0d mismatches.", compared, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
